// ===== design/msrg_pkg.sv =====
// shared types and constants for the motor speed ramp generator
// no dependencies
package msrg_pkg;

    localparam int TIME_BITS   = 16;
    localparam int SPEED_W     = 7;
    localparam int TARGET_W    = 8;
    localparam int RAMP_W      = 16;
    localparam int DIV_CNT_W   = $clog2(RAMP_W);
    localparam logic [TARGET_W-1:0] FULL_DUTY = TARGET_W'(100);
    localparam logic [31:0] HOLD_MAX = 32'((64'd1 << TIME_BITS) - 64'd1);

    typedef enum logic [1:0] {
        ACT_STEPPED = 2'd0,
        ACT_TIMED   = 2'd1,
        ACT_TICK    = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_STEP_PERCENT  = 2'd0,
        REG_STEP_DELAY    = 2'd1,
        REG_MIN_EFFECTIVE = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_EXEC = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic exec;
    } dp_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } dp_status_t;

endpackage

// ===== design/msrg_ctrl.sv =====
// sequencer for the ramp generator: accept, divide, update, deliver
// depends on msrg_pkg
module msrg_ctrl import msrg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!status.need_div || status.div_last)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
                state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = (state_reg == ST_OUT);
    assign cmd.load     = (state_reg == ST_IDLE) && in_valid;
    assign cmd.div_step = (state_reg == ST_DIV) && status.need_div;
    assign cmd.exec     = (state_reg == ST_EXEC);

endmodule

// ===== design/msrg_dp.sv =====
// datapath: settings, ramp state, bit-serial divider and result register
// depends on msrg_pkg
module msrg_dp import msrg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic [1:0]            in_action,
    input  logic [TARGET_W-1:0]   in_target,
    input  logic [SPEED_W-1:0]    in_start,
    input  logic [RAMP_W-1:0]     in_ramp,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic                  out_step,
    output logic [SPEED_W-1:0]    out_speed,
    output logic                  out_last,
    output logic                  out_busy
);

    function automatic logic [TIME_BITS-1:0] sat_time(input logic [RAMP_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 > HOLD_MAX)
            return '1;
        else
            return TIME_BITS'(v32);
    endfunction

    function automatic logic [SPEED_W-1:0] next_speed(
        input logic [SPEED_W-1:0] cur,
        input logic [SPEED_W-1:0] goal,
        input logic               timed,
        input logic [SPEED_W-1:0] step,
        input logic [SPEED_W-1:0] mn
    );
        logic [7:0] c8;
        logic [7:0] g8;
        logic [7:0] m8;
        logic [7:0] s8;
        logic [7:0] nx;
        c8 = 8'(cur);
        g8 = 8'(goal);
        m8 = 8'(mn);
        s8 = (step == '0) ? 8'd1 : 8'(step);
        if (timed)
        begin
            if (c8 < g8)
            begin
                nx = c8 + 8'd1;
                if (nx != 8'd0 && nx < m8)
                    nx = m8;
            end
            else
            begin
                nx = c8 - 8'd1;
                if (nx != 8'd0 && nx < m8)
                    nx = (g8 == 8'd0) ? 8'd0 : m8;
                if (nx < g8)
                    nx = g8;
            end
        end
        else
        begin
            if (c8 < g8)
            begin
                nx = c8 + s8;
                if (nx > g8)
                    nx = g8;
                if (nx != 8'd0 && nx < m8)
                    nx = m8;
            end
            else
            begin
                nx = (c8 > s8) ? c8 - s8 : 8'd0;
                if (g8 != 8'd0 && nx != 8'd0 && nx < m8)
                    nx = m8;
                if (nx < g8)
                    nx = g8;
            end
        end
        return nx[SPEED_W-1:0];
    endfunction

    // settings
    logic [SPEED_W-1:0]   step_pct_reg;
    logic [15:0]          step_dly_reg;
    logic [SPEED_W-1:0]   min_pct_reg;

    // latched transaction
    logic [1:0]           act_reg;
    logic [TARGET_W-1:0]  tgt_reg;
    logic [SPEED_W-1:0]   start_reg;

    // divider
    logic [RAMP_W-1:0]    quo_reg;
    logic [SPEED_W-1:0]   rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SPEED_W:0]     rem_sh;
    logic                 rem_ge;

    // ramp state
    logic                 active_reg, active_next;
    logic                 timed_reg, timed_next;
    logic [SPEED_W-1:0]   pres_reg, pres_next;
    logic [SPEED_W-1:0]   goal_reg, goal_next;
    logic [TIME_BITS-1:0] hps_reg, hps_next;
    logic [TIME_BITS-1:0] hrem_reg, hrem_next;

    // result
    logic                 ostep_reg, ostep_next;
    logic [SPEED_W-1:0]   ospeed_reg, ospeed_next;
    logic                 olast_reg, olast_next;
    logic                 obusy_reg;

    logic [SPEED_W-1:0]   tgt_sat;
    logic [SPEED_W-1:0]   goal_new;
    logic [SPEED_W-1:0]   steps;
    logic                 is_start, is_tick;
    logic                 start_go, start_idle, tick_go, do_issue;
    logic [TIME_BITS-1:0] hr_dec;
    logic [RAMP_W-1:0]    quo_floor;
    logic [SPEED_W-1:0]   cur_sel, goal_sel;
    logic                 timed_sel;
    logic [TIME_BITS-1:0] hold_sel;
    logic [SPEED_W-1:0]   nx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_pct_reg <= SPEED_W'(5);
            step_dly_reg <= 16'd10;
            min_pct_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_STEP_PERCENT:  step_pct_reg <= cfg_data[SPEED_W-1:0];
                REG_STEP_DELAY:    step_dly_reg <= cfg_data;
                REG_MIN_EFFECTIVE: min_pct_reg  <= cfg_data[SPEED_W-1:0];
                default:           ;
            endcase
        end
    end

    assign tgt_sat  = (tgt_reg > FULL_DUTY) ? FULL_DUTY[SPEED_W-1:0] : tgt_reg[SPEED_W-1:0];
    assign goal_new = (tgt_sat != '0 && tgt_sat < min_pct_reg) ? min_pct_reg : tgt_sat;
    assign steps    = (start_reg > goal_new) ? start_reg - goal_new : goal_new - start_reg;

    assign is_start   = (act_reg == ACT_STEPPED) || (act_reg == ACT_TIMED);
    assign is_tick    = (act_reg == ACT_TICK);
    assign start_idle = is_start && !active_reg;
    assign start_go   = start_idle && (start_reg != goal_new);
    assign tick_go    = is_tick && active_reg;

    assign status.need_div = start_go && (act_reg == ACT_TIMED);
    assign status.div_last = (cnt_reg == DIV_CNT_W'(RAMP_W - 1));

    assign rem_sh = {rem_reg, quo_reg[RAMP_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, steps});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= in_action;
            tgt_reg   <= in_target;
            start_reg <= in_start;
            quo_reg   <= in_ramp;
            rem_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? SPEED_W'(rem_sh - {1'b0, steps}) : rem_sh[SPEED_W-1:0];
            quo_reg <= {quo_reg[RAMP_W-2:0], rem_ge};
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end
    end

    assign hr_dec    = (hrem_reg != '0) ? hrem_reg - TIME_BITS'(1) : hrem_reg;
    assign quo_floor = (quo_reg == '0) ? RAMP_W'(1) : quo_reg;
    assign do_issue  = start_go || (tick_go && hr_dec == '0 && pres_reg != goal_reg);
    assign cur_sel   = start_go ? start_reg : pres_reg;
    assign goal_sel  = start_go ? goal_new : goal_reg;
    assign timed_sel = start_go ? (act_reg == ACT_TIMED) : timed_reg;
    assign hold_sel  = start_go ? (timed_sel ? sat_time(quo_floor) : sat_time(step_dly_reg))
                                : hps_reg;
    assign nx = next_speed(cur_sel, goal_sel, timed_sel, step_pct_reg, min_pct_reg);

    always_comb
    begin
        active_next = active_reg;
        timed_next  = timed_reg;
        pres_next   = pres_reg;
        goal_next   = goal_reg;
        hps_next    = hps_reg;
        hrem_next   = hrem_reg;
        if (start_idle)
        begin
            pres_next  = start_reg;
            goal_next  = goal_new;
            timed_next = (act_reg == ACT_TIMED);
        end
        if (start_go)
        begin
            hps_next    = hold_sel;
            active_next = 1'b1;
        end
        if (tick_go)
        begin
            hrem_next = hr_dec;
            if (hr_dec == '0 && pres_reg == goal_reg)
                active_next = 1'b0;
        end
        if (do_issue)
        begin
            pres_next = nx;
            hrem_next = hold_sel;
            if (hold_sel == '0 && nx == goal_sel)
                active_next = 1'b0;
        end
        ostep_next  = do_issue;
        ospeed_next = do_issue ? nx : (start_idle ? start_reg : pres_reg);
        olast_next  = do_issue && (nx == goal_sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            timed_reg  <= 1'b0;
            pres_reg   <= '0;
            goal_reg   <= '0;
            hps_reg    <= '0;
            hrem_reg   <= '0;
        end
        else if (cmd.exec)
        begin
            active_reg <= active_next;
            timed_reg  <= timed_next;
            pres_reg   <= pres_next;
            goal_reg   <= goal_next;
            hps_reg    <= hps_next;
            hrem_reg   <= hrem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            ostep_reg  <= ostep_next;
            ospeed_reg <= ospeed_next;
            olast_reg  <= olast_next;
            obusy_reg  <= active_next;
        end
    end

    assign out_step  = ostep_reg;
    assign out_speed = ospeed_reg;
    assign out_last  = olast_reg;
    assign out_busy  = obusy_reg;

endmodule

// ===== design/motor_speed_ramp_generator.sv =====
// motor speed ramp generator, top level: sequencer plus datapath
// depends on msrg_pkg, msrg_ctrl, msrg_dp
// sequence: a transaction is accepted, then passes the divide, update and deliver states
// a timed start divides its 16-bit ramp time bit-serially; next input only after m_tready
// settings are written through the cfg channel, which is always ready
// reset: async active-low, ramp idle, step 5, delay 10 ms, minimum 0
module motor_speed_ramp_generator import msrg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // target_percent[7:0], start_speed[14:8], ramp_time_ms[30:15]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // speed_percent[6:0], busy_res[7]
    output logic        m_tuser,   // step_valid
    output logic        m_tlast,   // last_step
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    dp_cmd_t            cmd;
    dp_status_t         status;
    logic [SPEED_W-1:0] speed;
    logic               busy;

    assign cfg_ready = 1'b1;

    msrg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    msrg_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_action (s_tuser),
        .in_target (s_tdata[7:0]),
        .in_start  (s_tdata[14:8]),
        .in_ramp   (s_tdata[30:15]),
        .cmd       (cmd),
        .status    (status),
        .out_step  (m_tuser),
        .out_speed (speed),
        .out_last  (m_tlast),
        .out_busy  (busy)
    );

    assign m_tdata = {busy, speed};

endmodule
